@@ rtl/mma_pkg.sv @@
package mma_pkg;

  localparam int DEF_MAX_DIM = 8;

  // Worst-case sum: the accumulator plus eight floored Q16.16 products of
  // magnitude up to 2^46 needs 51 bits signed.
  localparam int ACC_W = 52;

  localparam int VALUE_W = 32;
  localparam int DIM_REG_W = 4;
  localparam int IDX_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] MODE_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] MODE_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] MODE_LOAD_ACCUM = 2'd2;
  localparam logic [1:0] MODE_COMPUTE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

  localparam logic BANK_LEFT  = 1'b0;
  localparam logic BANK_RIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]                mode;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_row;
    logic [IDX_W-1:0]          out_col;
    logic signed [VALUE_W-1:0] out_value;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_REG_W-1:0] left_rows;
    logic [DIM_REG_W-1:0] inner_size;
    logic [DIM_REG_W-1:0] right_cols;
  } dims_t;

  typedef struct packed {
    logic               we;
    logic               bank;
    logic [IDX_W-1:0]   wr_row;
    logic [IDX_W-1:0]   wr_col;
    logic [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]   a_row;
    logic [IDX_W-1:0]   a_col;
    logic [IDX_W-1:0]   b_row;
    logic [IDX_W-1:0]   b_col;
  } opnd_req_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   wr_row;
    logic [IDX_W-1:0]   wr_col;
    logic [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]   rd_row;
    logic [IDX_W-1:0]   rd_col;
  } acc_req_t;

endpackage

@@ rtl/mma_operand_mem.sv @@
module mma_operand_mem #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM
) (
  input  logic                       clk,
  input  mma_pkg::opnd_req_t         req,
  output logic [mma_pkg::VALUE_W-1:0] a_data,
  output logic [mma_pkg::VALUE_W-1:0] b_data
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int DEPTH = 2 << (2 * DIM_W);

  // Left and right matrices share one array; the top address bit selects the bank.
  logic [mma_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[{req.bank, req.wr_row[DIM_W-1:0], req.wr_col[DIM_W-1:0]}] <= req.wr_data;
    end
    a_data <= mem[{mma_pkg::BANK_LEFT, req.a_row[DIM_W-1:0], req.a_col[DIM_W-1:0]}];
    b_data <= mem[{mma_pkg::BANK_RIGHT, req.b_row[DIM_W-1:0], req.b_col[DIM_W-1:0]}];
  end

endmodule

@@ rtl/mma_accum_mem.sv @@
module mma_accum_mem #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM
) (
  input  logic                        clk,
  input  mma_pkg::acc_req_t           req,
  output logic [mma_pkg::VALUE_W-1:0] rd_data
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int DEPTH = 1 << (2 * DIM_W);

  logic [mma_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[{req.wr_row[DIM_W-1:0], req.wr_col[DIM_W-1:0]}] <= req.wr_data;
    end
    rd_data <= mem[{req.rd_row[DIM_W-1:0], req.rd_col[DIM_W-1:0]}];
  end

endmodule

@@ rtl/mma_engine.sv @@
module mma_engine #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mma_pkg::dims_t              dims,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mma_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mma_pkg::out_item_t          out_item,
  output mma_pkg::opnd_req_t          opnd_req,
  input  logic [mma_pkg::VALUE_W-1:0] a_data,
  input  logic [mma_pkg::VALUE_W-1:0] b_data,
  output mma_pkg::acc_req_t           acc_req,
  input  logic [mma_pkg::VALUE_W-1:0] acc_data
);

  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = mma_pkg::ACC_W;
  localparam int VALUE_W = mma_pkg::VALUE_W;
  localparam int IDX_W = mma_pkg::IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] i, j, k;
  logic             rd_v, mul_v, init;
  logic signed [2*VALUE_W-1:0] prod;
  logic signed [2*VALUE_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]     acc;
  logic [VALUE_W-1:0]          sat_value;
  logic                        in_range;

  logic [CNT_W-1:0] nr, nk, nc;
  logic             in_fire, emit_fire, in_bounds, is_compute;
  logic             last_col, last_row, k_last;

  // Sizes above the array dimension are taken as the dimension.
  assign nr = (dims.left_rows > mma_pkg::DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                             : dims.left_rows[CNT_W-1:0];
  assign nk = (dims.inner_size > mma_pkg::DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                              : dims.inner_size[CNT_W-1:0];
  assign nc = (dims.right_cols > mma_pkg::DIM_REG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM)
                                                              : dims.right_cols[CNT_W-1:0];

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign is_compute = (in_item.mode == mma_pkg::MODE_COMPUTE);
  assign in_bounds  = ({1'b0, in_item.row} < (IDX_W + 1)'(MAX_DIM)) &&
                      ({1'b0, in_item.col} < (IDX_W + 1)'(MAX_DIM));

  assign last_col  = (CNT_W'(j) == nc - CNT_W'(1));
  assign last_row  = (CNT_W'(i) == nr - CNT_W'(1));
  assign k_last    = (CNT_W'(k) == nk - CNT_W'(1));
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);

  // Arithmetic shift of the Q32.32 product floors it to Q16.16.
  assign prod_sh  = prod >>> 16;
  assign in_range = (&acc[ACC_W-1:VALUE_W-1]) || !(|acc[ACC_W-1:VALUE_W-1]);
  assign sat_value = in_range ? acc[VALUE_W-1:0]
                   : (acc[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                   : {1'b0, {(VALUE_W-1){1'b1}}});

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && is_compute && (nr != '0) && (nc != '0)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = (nk == '0) ? ST_FLUSH : ST_MAC;
      end
      ST_MAC: begin
        if (k_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!rd_v && !mul_v) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = (last_row && last_col) ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
      mul_v <= 1'b0;
      init  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == ST_MAC);
      mul_v <= rd_v;
      init  <= (state == ST_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        i <= '0;
        j <= '0;
      end
      ST_FETCH: k <= '0;
      ST_MAC:   k <= k + DIM_W'(1);
      ST_EMIT: begin
        if (emit_fire) begin
          if (last_col) begin
            j <= '0;
            i <= i + DIM_W'(1);
          end else begin
            j <= j + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Read data comes from a registered memory read, and the product is registered
  // before it is added, so a term passes both registers on its way to the sum.
  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
    if (init) begin
      acc <= {{(ACC_W-VALUE_W){acc_data[VALUE_W-1]}}, acc_data};
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_item.out_row   <= IDX_W'(i);
      out_item.out_col   <= IDX_W'(j);
      out_item.out_value <= sat_value;
      out_item.last      <= last_row && last_col;
    end
  end

  always_comb begin
    opnd_req.we      = in_fire && in_bounds &&
                       ((in_item.mode == mma_pkg::MODE_LOAD_LEFT) ||
                        (in_item.mode == mma_pkg::MODE_LOAD_RIGHT));
    opnd_req.bank    = (in_item.mode == mma_pkg::MODE_LOAD_RIGHT) ? mma_pkg::BANK_RIGHT
                                                                  : mma_pkg::BANK_LEFT;
    opnd_req.wr_row  = in_item.row;
    opnd_req.wr_col  = in_item.col;
    opnd_req.wr_data = in_item.value;
    opnd_req.a_row   = IDX_W'(i);
    opnd_req.a_col   = IDX_W'(k);
    opnd_req.b_row   = IDX_W'(k);
    opnd_req.b_col   = IDX_W'(j);

    // Loads happen only while idle and write-back only while emitting, so
    // the two never share a cycle.
    acc_req.we      = emit_fire || (in_fire && in_bounds &&
                      (in_item.mode == mma_pkg::MODE_LOAD_ACCUM));
    acc_req.wr_row  = emit_fire ? IDX_W'(i) : in_item.row;
    acc_req.wr_col  = emit_fire ? IDX_W'(j) : in_item.col;
    acc_req.wr_data = emit_fire ? sat_value : in_item.value;
    acc_req.rd_row  = IDX_W'(i);
    acc_req.rd_col  = IDX_W'(j);
  end

endmodule

@@ rtl/matrix_multiply_accumulate.sv @@
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_index, cfg_data (4-bit sizes)
// in        in         in_valid/in_ready    in_item: mode, row, col, value
// out       out        out_valid/out_ready  out_item: out_row, out_col, out_value, last
//
// A load item is stored, if in bounds, in the cycle that accepts it. After its accepting
// cycle a compute item runs, for each result element, an accumulator read, one operand
// read per inner step through the two read ports of the operand memory, a drain of the
// multiply and add, and one emit; when inner is zero only the accumulator read, the
// drain and the emit remain, and any output stall adds to the run.
// Items are taken only while no compute run is in progress.
// Reset sets all three sizes to 8; the memories are not cleared.
// A stalled output holds the run at its emit step without losing a result.
module matrix_multiply_accumulate #(
  parameter int MAX_DIM = mma_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mma_pkg::DIM_REG_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mma_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mma_pkg::out_item_t            out_item
);

  mma_pkg::dims_t     dims;
  mma_pkg::opnd_req_t opnd_req;
  mma_pkg::acc_req_t  acc_req;
  logic [mma_pkg::VALUE_W-1:0] a_data, b_data, acc_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.left_rows  <= 4'd8;
      dims.inner_size <= 4'd8;
      dims.right_cols <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        mma_pkg::REG_LEFT_ROWS:  dims.left_rows  <= cfg_data;
        mma_pkg::REG_INNER_SIZE: dims.inner_size <= cfg_data;
        mma_pkg::REG_RIGHT_COLS: dims.right_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  mma_operand_mem #(.MAX_DIM(MAX_DIM)) u_operand_mem (
    .clk    (clk),
    .req    (opnd_req),
    .a_data (a_data),
    .b_data (b_data)
  );

  mma_accum_mem #(.MAX_DIM(MAX_DIM)) u_accum_mem (
    .clk     (clk),
    .req     (acc_req),
    .rd_data (acc_data)
  );

  mma_engine #(.MAX_DIM(MAX_DIM)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .opnd_req  (opnd_req),
    .a_data    (a_data),
    .b_data    (b_data),
    .acc_req   (acc_req),
    .acc_data  (acc_data)
  );

  // Operand writes come only from accepted load items.
  assert property (@(posedge clk) disable iff (rst)
    opnd_req.we |-> (in_valid && in_ready))
    else $error("operand write without an accepted item");

  // An accumulator write that is not a load is a write-back, which always
  // comes with a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    (acc_req.we && !(in_valid && in_ready)) |=> out_valid)
    else $error("accumulator write-back without a result");

  // While a result that is not the last of its run is shown, the run is busy.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.last) |-> !in_ready)
    else $error("input taken in the middle of a compute run");

endmodule
